@@ design/psu_pkg.sv @@
package psu_pkg;

  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;

  localparam logic [7:0] LAST_FILTER = 8'd4;
  localparam int AVG_SHIFT = 1;

  localparam logic REG_LINE_BYTES  = 1'b0;
  localparam logic REG_PIXEL_BYTES = 1'b1;

  typedef struct packed {
    logic [2:0] filter;
    logic       first_row;
    logic       left_ok;
  } pred_ctl_t;

endpackage

@@ design/psu_ram.sv @@
module psu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/psu_predict.sv @@
module psu_predict (
  input  psu_pkg::pred_ctl_t ctl,
  input  logic [7:0]         data,
  input  logic [7:0]         left_hist,
  input  logic [7:0]         upper_left_hist,
  input  logic [7:0]         above,
  output logic [7:0]         x,
  output logic [7:0]         b
);

  logic [7:0] a;
  logic [7:0] c;
  logic [8:0] sum_ab;
  logic [8:0] twice_c;
  logic [7:0] avg;
  logic [7:0] dist_a;
  logic [7:0] dist_b;
  logic [8:0] dist_c;
  logic [7:0] paeth;

  always_comb begin
    a = ctl.left_ok ? left_hist : 8'd0;
    b = ctl.first_row ? 8'd0 : above;
    c = (ctl.left_ok && !ctl.first_row) ? upper_left_hist : 8'd0;

    sum_ab  = {1'b0, a} + {1'b0, b};
    twice_c = {c, 1'b0};
    avg     = 8'(sum_ab >> psu_pkg::AVG_SHIFT);

    // The Paeth distances from p = a + b - c, written without p.
    dist_a = (b > c) ? b - c : c - b;
    dist_b = (a > c) ? a - c : c - a;
    dist_c = (sum_ab > twice_c) ? sum_ab - twice_c : twice_c - sum_ab;

    if (dist_a <= dist_b && {1'b0, dist_a} <= dist_c) begin
      paeth = a;
    end else if ({1'b0, dist_b} <= dist_c) begin
      paeth = b;
    end else begin
      paeth = c;
    end

    case (ctl.filter)
      psu_pkg::FILT_SUB:   x = data + a;
      psu_pkg::FILT_UP:    x = data + b;
      psu_pkg::FILT_AVG:   x = data + avg;
      psu_pkg::FILT_PAETH: x = data + paeth;
      default:             x = data;
    endcase
  end

endmodule

@@ design/png_scanline_unfilter.sv @@
// PNG scanline unfilter: takes the inflated stream one byte per request, the filter type
// byte first on each line, and returns one reconstructed byte per data byte. It sustains
// one byte per clock while out_ready holds; a data byte goes from the s1 stage registers
// to the output register. The previous line sits in a MAX_LINE_BYTES by 8 line store RAM
// that is read when a byte is accepted and written when the byte leaves the predictor
// stage; it needs no clearing pass after reset because the first row of an image never
// uses it. A filter type above Paeth gives one result with bad_filter set, after which
// requests are taken and dropped until one arrives with image_start set.
module png_scanline_unfilter #(
  parameter int MAX_LINE_BYTES  = 32768,
  parameter int MAX_PIXEL_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        image_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  pixel_byte,
  output logic        line_end,
  output logic        bad_filter
);

  localparam int COL_W   = MAX_LINE_BYTES > 1 ? $clog2(MAX_LINE_BYTES) : 1;
  localparam int HIST_IW = MAX_PIXEL_BYTES > 1 ? $clog2(MAX_PIXEL_BYTES) : 1;

  logic [15:0] line_bytes;
  logic [3:0]  pixel_bytes;
  logic [31:0] line_len;
  logic [3:0]  pix_len;
  logic [3:0]  pix_back;

  logic [COL_W-1:0] column;
  logic [COL_W-1:0] column_next;
  logic             at_filter;
  logic             at_filter_next;
  logic             first_row;
  logic             first_row_next;
  logic             halted;
  logic             halted_next;
  logic [2:0]       filter_kind;
  logic [2:0]       filter_kind_next;

  logic             eff_halted;
  logic             eff_at_filter;
  logic             eff_first;
  logic [COL_W-1:0] eff_col;
  logic             take_bad;
  logic             take_data;
  logic             is_last;
  logic             accept;
  logic             s1_advance;

  logic               s1_valid;
  logic               s1_bad;
  logic               s1_last;
  logic [7:0]         s1_data;
  logic [COL_W-1:0]   s1_column;
  psu_pkg::pred_ctl_t s1_ctl;

  logic [7:0] left_hist  [MAX_PIXEL_BYTES];
  logic [7:0] upper_hist [MAX_PIXEL_BYTES];
  logic [7:0] above;
  logic [7:0] pred_x;
  logic [7:0] pred_b;
  logic       store_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_bytes  <= 16'd1;
      pixel_bytes <= 4'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        psu_pkg::REG_LINE_BYTES:  line_bytes  <= cfg_data;
        psu_pkg::REG_PIXEL_BYTES: pixel_bytes <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (line_bytes == 16'd0) begin
      line_len = 32'd1;
    end else if (32'(line_bytes) > 32'(MAX_LINE_BYTES)) begin
      line_len = 32'(MAX_LINE_BYTES);
    end else begin
      line_len = 32'(line_bytes);
    end
    if (pixel_bytes == 4'd0) begin
      pix_len = 4'd1;
    end else if (32'(pixel_bytes) > 32'(MAX_PIXEL_BYTES)) begin
      pix_len = 4'(MAX_PIXEL_BYTES);
    end else begin
      pix_len = pixel_bytes;
    end
    pix_back = pix_len - 4'd1;
  end

  assign s1_advance = !out_valid || out_ready;
  assign in_ready   = !s1_valid || s1_advance;
  assign accept     = in_valid && in_ready;

  always_comb begin
    eff_halted    = halted;
    eff_at_filter = at_filter;
    eff_first     = first_row;
    eff_col       = column;
    if (image_start) begin
      eff_halted    = 1'b0;
      eff_at_filter = 1'b1;
      eff_first     = 1'b1;
      eff_col       = '0;
    end

    column_next      = column;
    at_filter_next   = at_filter;
    first_row_next   = first_row;
    halted_next      = halted;
    filter_kind_next = filter_kind;
    take_bad         = 1'b0;
    take_data        = 1'b0;
    is_last          = 1'b0;

    if (accept) begin
      column_next    = eff_col;
      at_filter_next = eff_at_filter;
      first_row_next = eff_first;
      halted_next    = eff_halted;
      if (!eff_halted) begin
        if (eff_at_filter) begin
          if (data_byte > psu_pkg::LAST_FILTER) begin
            halted_next = 1'b1;
            take_bad    = 1'b1;
          end else begin
            filter_kind_next = data_byte[2:0];
            at_filter_next   = 1'b0;
            column_next      = '0;
          end
        end else begin
          take_data = 1'b1;
          if (32'(eff_col) + 32'd1 >= line_len) begin
            is_last        = 1'b1;
            column_next    = '0;
            at_filter_next = 1'b1;
            first_row_next = 1'b0;
          end else begin
            column_next = eff_col + COL_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column      <= '0;
      at_filter   <= 1'b1;
      first_row   <= 1'b1;
      halted      <= 1'b0;
      filter_kind <= psu_pkg::FILT_NONE;
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      column      <= column_next;
      at_filter   <= at_filter_next;
      first_row   <= first_row_next;
      halted      <= halted_next;
      filter_kind <= filter_kind_next;
      if (take_bad || take_data) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (s1_advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_bad           <= take_bad;
      s1_last          <= is_last;
      s1_data          <= data_byte;
      s1_column        <= eff_col;
      s1_ctl.filter    <= filter_kind;
      s1_ctl.first_row <= eff_first;
      s1_ctl.left_ok   <= 32'(eff_col) >= 32'(pix_len);
    end
    if (s1_advance) begin
      pixel_byte <= s1_bad ? 8'd0 : pred_x;
      line_end   <= s1_bad ? 1'b0 : s1_last;
      bad_filter <= s1_bad;
    end
  end

  assign store_we = s1_valid && !s1_bad && s1_advance;

  // The histories are never cleared: a neighbor to the left is used only once the line has
  // pushed at least pix_len bytes (pixel_bytes clamped to 1..MAX_PIXEL_BYTES) of its own.
  always_ff @(posedge clk) begin
    if (store_we) begin
      for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
        left_hist[i]  <= left_hist[i-1];
        upper_hist[i] <= upper_hist[i-1];
      end
      left_hist[0]  <= pred_x;
      upper_hist[0] <= pred_b;
    end
  end

  psu_ram #(
    .WIDTH(8),
    .DEPTH(MAX_LINE_BYTES)
  ) u_line_store (
    .clk  (clk),
    .we   (store_we),
    .waddr(s1_column),
    .wdata(pred_x),
    .re   (take_data),
    .raddr(eff_col),
    .rdata(above)
  );

  psu_predict u_predict (
    .ctl            (s1_ctl),
    .data           (s1_data),
    .left_hist      (left_hist[pix_back[HIST_IW-1:0]]),
    .upper_left_hist(upper_hist[pix_back[HIST_IW-1:0]]),
    .above          (above),
    .x              (pred_x),
    .b              (pred_b)
  );

  a_bad_result_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_filter |-> pixel_byte == 8'd0 && !line_end)
    else $error("bad filter result carries data");

  a_halted_drops: assert property (@(posedge clk) disable iff (rst)
    accept && halted && !image_start |=> !s1_valid)
    else $error("request taken while halted produced a result");

  a_line_wrap: assert property (@(posedge clk) disable iff (rst)
    take_data && is_last |=> at_filter && column == '0 && !first_row)
    else $error("line end did not return to the filter byte");

endmodule
